### src/swpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swpe_pkg
// Types, constants and the CORDIC angle table for the string point evolver.
// ----------------------------------------------------------------------------
package swpe_pkg;

    localparam int REG_W      = 21;              // config registers and point index
    localparam int PHASE_W    = 32;              // Q0.32 fraction of a turn
    localparam int DVD_W      = REG_W + PHASE_W; // (index - 1) << 32
    localparam int VAL_W      = 32;              // Q3.28 displacement
    localparam int CORDIC_W   = 34;              // Q2.30 with headroom
    localparam int CORDIC_ITERS = 30;
    localparam int ITER_W     = 5;
    localparam int DIV_CNT_W  = 6;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [26:0]         COEF_Q28    = -27'sd48318384;

    localparam logic [1:0] REG_NUM_POINTS = 2'd0;
    localparam logic [1:0] REG_NUM_STEPS  = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SINE,
        ST_STEP,
        ST_OUT
    } state_t;

    // atan(2^-i) as a Q0.32 fraction of a turn
    function automatic logic [29:0] atan_turn(input logic [ITER_W-1:0] i);
        logic [29:0] a;
        case (i)
            5'd0:  a = 30'h20000000;
            5'd1:  a = 30'h12E4051E;
            5'd2:  a = 30'h09FB385B;
            5'd3:  a = 30'h051111D4;
            5'd4:  a = 30'h028B0D43;
            5'd5:  a = 30'h0145D7E1;
            5'd6:  a = 30'h00A2F61E;
            5'd7:  a = 30'h00517C55;
            5'd8:  a = 30'h0028BE53;
            5'd9:  a = 30'h00145F2F;
            5'd10: a = 30'h000A2F98;
            5'd11: a = 30'h000517CC;
            5'd12: a = 30'h00028BE6;
            5'd13: a = 30'h000145F3;
            5'd14: a = 30'h0000A2FA;
            5'd15: a = 30'h0000517D;
            5'd16: a = 30'h000028BE;
            5'd17: a = 30'h0000145F;
            5'd18: a = 30'h00000A30;
            5'd19: a = 30'h00000518;
            5'd20: a = 30'h0000028C;
            5'd21: a = 30'h00000146;
            5'd22: a = 30'h000000A3;
            5'd23: a = 30'h00000051;
            5'd24: a = 30'h00000029;
            5'd25: a = 30'h00000014;
            5'd26: a = 30'h0000000A;
            5'd27: a = 30'h00000005;
            5'd28: a = 30'h00000003;
            5'd29: a = 30'h00000001;
            default: a = 30'h0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

### src/swpe_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swpe_div
// Restoring divider, one quotient bit per cycle: phase = ((idx-1) << 32) / d,
// low 32 quotient bits kept.
// ----------------------------------------------------------------------------
module swpe_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [swpe_pkg::REG_W-1:0]    dividend_hi,
    input  wire logic [swpe_pkg::REG_W-1:0]    divisor,
    output logic                               done,
    output logic [swpe_pkg::PHASE_W-1:0]       quotient
);
    import swpe_pkg::*;

    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [REG_W-1:0]     dsr_reg, dsr_next;
    logic [REG_W-1:0]     rem_reg, rem_next;
    logic [PHASE_W-1:0]   quot_reg, quot_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [REG_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = {dividend_hi, {PHASE_W{1'b0}}};
            dsr_next  = divisor;
            rem_next  = '0;
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next  = fits ? REG_W'(trial - {1'b0, dsr_reg}) : trial[REG_W-1:0];
            quot_next = {quot_reg[PHASE_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
`default_nettype wire

### src/swpe_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swpe_cordic
// Rotation-mode CORDIC, one iteration per cycle, sine of a Q0.32 turn in Q3.28.
// ----------------------------------------------------------------------------
module swpe_cordic (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [swpe_pkg::PHASE_W-1:0]  phase,
    output logic                               done,
    output logic signed [swpe_pkg::VAL_W-1:0]  sine
);
    import swpe_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [CORDIC_W-1:0] z_reg, z_next;
    logic [1:0]                 quad_reg, quad_next;
    logic [ITER_W-1:0]          iter_reg, iter_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic signed [CORDIC_W-1:0] dx, dy, da;
    logic signed [CORDIC_W:0]   s_sel, s_rnd, s_clip;

    localparam logic signed [CORDIC_W:0] S_MAX = 35'sd268435456;

    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;
    assign da = signed'({{(CORDIC_W-30){1'b0}}, atan_turn(iter_reg)});

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        quad_next = quad_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            z_next    = signed'({{(CORDIC_W-30){1'b0}}, phase[29:0]});
            quad_next = phase[31:30];
            iter_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!z_reg[CORDIC_W-1]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - da;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + da;
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_W'(CORDIC_ITERS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // fold the quadrant back in, round Q2.30 to Q3.28, clamp to +/-1.0
    always_comb begin
        case (quad_reg)
            2'd0:    s_sel = (CORDIC_W+1)'(y_reg);
            2'd1:    s_sel = (CORDIC_W+1)'(x_reg);
            2'd2:    s_sel = -((CORDIC_W+1)'(y_reg));
            default: s_sel = -((CORDIC_W+1)'(x_reg));
        endcase
        s_rnd = (s_sel + 35'sd2) >>> 2;
        if (s_rnd > S_MAX)
            s_clip = S_MAX;
        else if (s_rnd < -S_MAX)
            s_clip = -S_MAX;
        else
            s_clip = s_rnd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        quad_reg <= quad_next;
    end

    assign done = done_reg;
    assign sine = VAL_W'(s_clip);

endmodule
`default_nettype wire

### src/string_wave_point_evolve.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// string_wave_point_evolve
// Flow: an accepted request runs the divider, then the CORDIC, then num_steps time
//   steps (none with zero steps, or at an end point, which is pinned to zero), then loads the output register.
// Handshake: s_tready is high only while idle, so the next request waits for this one;
//   a stalled m_tready holds a new result in ST_OUT until the previous one is taken.
// Reset: synchronous, active low; num_points resets to 20, num_steps to 1.
// ----------------------------------------------------------------------------
module string_wave_point_evolve #(
    parameter int MAX_POINTS = 1048576,
    parameter int MAX_STEPS  = 1048576
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [20:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [20:0] point_index, [23:21] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] final_value
);
    import swpe_pkg::*;

    state_t state_reg, state_next;

    logic [REG_W-1:0]        num_points_reg, num_steps_reg;
    logic [REG_W-1:0]        idx_eff, n_eff, steps_eff, denom;
    logic                    in_accept;

    logic                    is_end_reg, is_end_next;
    logic [REG_W-1:0]        steps_reg, steps_next;
    logic [REG_W-1:0]        cnt_reg, cnt_next;
    logic signed [VAL_W-1:0] v_reg, v_next;
    logic signed [VAL_W-1:0] prev_reg, prev_next;
    logic                    m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]        m_data_reg, m_data_next;

    logic                    div_done, cordic_done;
    logic [PHASE_W-1:0]      phase;
    logic signed [VAL_W-1:0] sine;

    logic signed [58:0]      prod_full, prod_rnd;
    logic signed [33:0]      sum;
    logic signed [VAL_W-1:0] v_step;

    // clamp the registers and the index as the request is taken
    always_comb begin
        idx_eff   = (s_tdata[REG_W-1:0] == '0) ? REG_W'(1) : s_tdata[REG_W-1:0];
        n_eff     = (32'(num_points_reg) > 32'(MAX_POINTS)) ? REG_W'(MAX_POINTS)
                                                            : num_points_reg;
        steps_eff = (32'(num_steps_reg) > 32'(MAX_STEPS)) ? REG_W'(MAX_STEPS)
                                                          : num_steps_reg;
        denom     = (n_eff >= REG_W'(2)) ? n_eff - 1'b1 : REG_W'(1);
    end

    assign in_accept = s_tvalid && s_tready;

    swpe_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (in_accept),
        .dividend_hi (idx_eff - 1'b1),
        .divisor     (denom),
        .done        (div_done),
        .quotient    (phase)
    );

    swpe_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_done),
        .phase   (phase),
        .done    (cordic_done),
        .sine    (sine)
    );

    // one time step: 2v - prev + round(c * v), saturated
    always_comb begin
        prod_full = 59'(COEF_Q28) * 59'(v_reg);
        prod_rnd  = (prod_full + 59'sd134217728) >>> 28;
        sum       = 34'(v_reg) + 34'(v_reg) - 34'(prev_reg) + 34'(prod_rnd);
        if (sum > 34'sd2147483647)
            v_step = 32'sh7FFFFFFF;
        else if (sum < -34'sd2147483648)
            v_step = 32'sh80000000;
        else
            v_step = sum[31:0];
    end

    always_comb begin
        state_next   = state_reg;
        is_end_next  = is_end_reg;
        steps_next   = steps_reg;
        cnt_next     = cnt_reg;
        v_next       = v_reg;
        prev_next    = prev_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    is_end_next = (idx_eff == REG_W'(1)) || (idx_eff == n_eff);
                    steps_next  = steps_eff;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done)
                    state_next = ST_SINE;
            end
            ST_SINE: begin
                if (cordic_done) begin
                    v_next    = sine;
                    prev_next = sine;
                    cnt_next  = steps_reg;
                    if (steps_reg == '0) begin
                        state_next = ST_OUT;
                    end else if (is_end_reg) begin
                        v_next     = '0;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                v_next    = v_step;
                prev_next = v_reg;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == REG_W'(1))
                    state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = v_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_points_reg <= REG_W'(20);
            num_steps_reg  <= REG_W'(1);
            m_valid_reg    <= 1'b0;
            cnt_reg        <= '0;
            is_end_reg     <= 1'b0;
            steps_reg      <= '0;
        end else begin
            if (cfg_wr_en && cfg_addr == REG_NUM_POINTS)
                num_points_reg <= cfg_wdata;
            if (cfg_wr_en && cfg_addr == REG_NUM_STEPS)
                num_steps_reg <= cfg_wdata;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            is_end_reg  <= is_end_next;
            steps_reg   <= steps_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg      <= v_next;
        prev_reg   <= prev_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTH
    a_accept_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> state_reg == ST_DIV)
        else $error("request accepted but divider not running");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside its phase");

    a_cordic_done_in_sine: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_done |-> state_reg == ST_SINE)
        else $error("CORDIC finished outside its phase");

    a_step_cnt_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_STEP |-> cnt_reg != '0)
        else $error("time step loop entered with zero count");

    a_out_loads_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && (!m_valid_reg || m_tready)) |=> m_tvalid)
        else $error("result not presented after final step");
`endif

endmodule
`default_nettype wire

### verif/swpe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpe_checker
// Watches the config port and both stream channels of the string point
// evolver. It computes the final displacement of every accepted point in
// Q3.28 and compares each returned value, in order, with that prediction.
// ----------------------------------------------------------------------------
module swpe_checker #(
    parameter int MAX_POINTS = 1048576,
    parameter int MAX_STEPS  = 1048576
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [20:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,    // [20:0] point_index, [23:21] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // [31:0] final_value
    output int          fail_count,
    output int          outstanding
);
    import swpe_pkg::*;

    localparam longint GAIN_Q30  = 652032874;
    localparam longint DAMP_Q28  = -48318384;
    localparam longint UNIT_Q28  = 268435456;
    localparam longint HALF_Q28  = 134217728;
    localparam longint VAL_MAX   = 2147483647;
    localparam longint VAL_MIN   = -64'sd2147483648;

    typedef struct {
        logic [20:0]        index;
        logic signed [31:0] value;
    } point_result_t;

    // atan(2^-i) in turns, Q0.32
    longint atan_lut [0:29] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
    };

    logic [20:0]   points_reg;
    logic [20:0]   steps_reg;
    point_result_t pending_values [$];

    function automatic longint clamp32(input longint v);
        if (v > VAL_MAX) return VAL_MAX;
        if (v < VAL_MIN) return VAL_MIN;
        return v;
    endfunction

    // sine of a Q0.32 turn as Q3.28, rotation mode CORDIC on the first quadrant
    function automatic longint sine_of_turn(input logic [31:0] phase);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint s;
        x = GAIN_Q30;
        y = 0;
        z = longint'({34'd0, phase[29:0]});
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_lut[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_lut[i];
            end
        end
        case (phase[31:30])
            2'd0:    s = y;
            2'd1:    s = x;
            2'd2:    s = -y;
            default: s = -x;
        endcase
        s = (s + 2) >>> 2;
        if (s > UNIT_Q28) s = UNIT_Q28;
        if (s < -UNIT_Q28) s = -UNIT_Q28;
        return s;
    endfunction

    function automatic logic signed [31:0] evolve_point(input logic [20:0] index_in,
                                                        input logic [20:0] points_in,
                                                        input logic [20:0] steps_in);
        longint unsigned idx;
        longint unsigned n;
        longint unsigned steps;
        longint unsigned denom;
        longint unsigned t;
        logic [31:0]     phase;
        longint          v;
        longint          prev;
        longint          nxt;
        longint          damp;
        idx   = index_in;
        n     = points_in;
        steps = steps_in;
        if (idx == 0) idx = 1;
        if (n > MAX_POINTS) n = MAX_POINTS;
        if (steps > MAX_STEPS) steps = MAX_STEPS;
        denom = (n >= 2) ? n - 1 : 1;
        phase = 32'(((idx - 1) << 32) / denom);
        v     = sine_of_turn(phase);
        prev  = v;
        // end points are pinned once any step is taken
        if (steps > 0 && (idx == 1 || idx == n)) begin
            v = 0;
        end else begin
            for (t = 0; t < steps; t++) begin
                damp = (DAMP_Q28 * v + HALF_Q28) >>> 28;
                nxt  = clamp32(2 * v - prev + damp);
                prev = v;
                v    = nxt;
            end
        end
        return 32'(v);
    endfunction

    always @(posedge aclk) begin : track
        point_result_t head;
        int            errs;
        int            delta;
        errs  = 0;
        delta = 0;
        if (!aresetn) begin
            points_reg  <= 21'd20;
            steps_reg   <= 21'd1;
            fail_count  <= 0;
            outstanding <= 0;
            pending_values.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_NUM_POINTS: points_reg <= cfg_wdata;
                    REG_NUM_STEPS:  steps_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                head.index = s_tdata[20:0];
                head.value = evolve_point(s_tdata[20:0], points_reg, steps_reg);
                pending_values.push_back(head);
                delta++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_values.size() == 0) begin
                    $display("%0t: final_value %0d returned with no request pending",
                             $time, $signed(m_tdata));
                    errs++;
                end else begin
                    head = pending_values.pop_front();
                    delta--;
                    if (m_tdata !== head.value) begin
                        $display("%0t: final_value for point %0d: expected %0d, got %0d",
                                 $time, head.index, head.value, $signed(m_tdata));
                        errs++;
                    end
                end
            end
            fail_count  <= fail_count + errs;
            outstanding <= outstanding + delta;
        end
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives point requests and register settings into the string point evolver
// with random gaps and output stalls; a checker beside the block predicts and
// compares every returned displacement.
// ----------------------------------------------------------------------------
module tb;
    import swpe_pkg::*;

    localparam int MAX_POINTS  = 1048576;
    localparam int MAX_STEPS   = 1048576;
    // slowest request runs about a million steps; allow several times that
    localparam int STALL_LIMIT = 4200000;
    localparam int TAIL_CYCLES = 600;

    localparam logic [1:0]  REG_SPARE_A = 2'd2;
    localparam logic [1:0]  REG_SPARE_B = 2'd3;
    localparam logic [20:0] FIELD_ONES  = 21'h1FFFFF;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = 2'd0;
    logic [20:0] cfg_wdata = 21'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = 24'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;

    logic        steady    = 1'b0;
    int          fail_count;
    int          outstanding;
    int          quiet_cycles = 0;
    int          n_sent       = 0;
    int          settings_used = 1;

    string_wave_point_evolve #(
        .MAX_POINTS(MAX_POINTS),
        .MAX_STEPS (MAX_STEPS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    swpe_checker #(
        .MAX_POINTS(MAX_POINTS),
        .MAX_STEPS (MAX_STEPS)
    ) u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 28);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_point(input logic [20:0] idx);
        if (!steady) begin
            while ($urandom_range(99) < 28) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, idx};
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    // drop valid and hold until every request has returned its result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [20:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_string(input logic [20:0] pts, input logic [20:0] stp);
        wait_drained();
        write_reg(REG_NUM_POINTS, pts);
        write_reg(REG_NUM_STEPS, stp);
        settings_used++;
    endtask

    initial begin : stimulus
        logic [20:0] pts;
        logic [20:0] stp;
        logic [20:0] idx;
        logic [20:0] n_eff;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values: 20 points, one step
        send_point(21'd0);
        send_point(21'd1);
        send_point(21'd10);
        send_point(21'd20);
        send_point(21'd21);
        send_point(FIELD_ONES);

        // zero steps leaves the start value, end points included
        set_string(21'd20, 21'd0);
        send_point(21'd1);
        send_point(21'd20);
        send_point(21'd6);

        // too few points: phase collapses to zero
        set_string(21'd0, 21'd2);
        send_point(21'd5);
        set_string(21'd1, 21'd2);
        send_point(21'd7);

        // point count above the maximum clamps to it
        set_string(FIELD_ONES, 21'd3);
        send_point(21'd1048576);
        send_point(21'd1048577);
        send_point(21'd524289);

        set_string(21'd1048576, 21'd2);
        send_point(21'd1048576);
        send_point(21'd1);

        // writes to unused indexes must change nothing
        wait_drained();
        write_reg(REG_SPARE_A, FIELD_ONES);
        write_reg(REG_SPARE_B, 21'd0);
        send_point(21'd9);

        // step count above the maximum clamps: one long request
        set_string(21'd20, FIELD_ONES);
        send_point(21'd3);

        for (int ph = 0; ph < 5; ph++) begin
            case ($urandom_range(3))
                0:       pts = 21'($urandom_range(20, 50));
                1:       pts = 21'($urandom_range(20, 100000));
                2:       pts = 21'($urandom);
                default: pts = 21'($urandom_range(20, 2000));
            endcase
            stp = (ph == 4) ? 21'($urandom_range(100, 400)) : 21'($urandom_range(0, 40));
            set_string(pts, stp);
            n_eff = (pts > MAX_POINTS) ? 21'(MAX_POINTS) : pts;
            steady <= (ph == 2);
            repeat (20) begin
                case ($urandom_range(9))
                    0:       idx = 21'($urandom_range(1));
                    1:       idx = n_eff;
                    2:       idx = n_eff + 21'($urandom_range(1, 3));
                    3:       idx = 21'($urandom);
                    default: idx = 21'($urandom_range(1, n_eff));
                endcase
                send_point(idx);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Evolved %0d points under %0d string settings with random gaps and stalls.",
                 n_sent, settings_used);
        $display("Included end points, wrapped and zero indexes, zero steps, clamped counts.");
        if (fail_count == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
src/swpe_pkg.sv
src/swpe_div.sv
src/swpe_cordic.sv
src/string_wave_point_evolve.sv
verif/swpe_checker.sv
verif/tb.sv
